>>> rtl/sbefx_pkg.sv
// Shared types, codes and defaults of the message field extractor.
`default_nettype none
package sbefx_pkg;

  // Defaults for the top-level parameters.
  localparam int HEADER_BYTES_DEF = 8;
  localparam int BODY_BYTES_DEF   = 256;
  localparam int FIELD_SLOTS_DEF  = 32;
  localparam int STRING_BYTES_DEF = 16;

  // At most this many results come from one message.
  localparam int MAX_RESULTS = 64;
  localparam int RES_W       = 7;

  // Width of a body position: offset plus string length.
  localparam int POS_W = 10;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_FIELD      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN    = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE = 2'd2;
  localparam logic [1:0] ST_TOO_LARGE  = 2'd3;

  // Type codes.
  localparam logic [3:0] KIND_CHAR   = 4'd8;
  localparam logic [3:0] KIND_STRING = 4'd9;

  // String padding bytes.
  localparam logic [7:0] PAD_NUL   = 8'h00;
  localparam logic [7:0] PAD_SPACE = 8'h20;

  // One descriptor slot.
  typedef struct packed {
    logic        valid;
    logic [15:0] tmpl;
    logic [7:0]  offset;
    logic [3:0]  kind;
    logic [4:0]  length;
  } slot_t;

  // One job handed from the front to the back.
  typedef struct packed {
    logic        emit;
    logic [1:0]  status;
    logic [15:0] tmpl;
    logic [15:0] blen;
  } job_t;

endpackage
`default_nettype wire

>>> rtl/sbefx_in_if.sv
// Input channel: descriptor loads and message bytes.
`default_nettype none
interface sbefx_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  data_byte;
  logic        end_of_buffer;
  logic [4:0]  slot_index;
  logic        slot_valid;
  logic [15:0] slot_template;
  logic [7:0]  slot_offset;
  logic [3:0]  slot_kind;
  logic [4:0]  slot_length;

  modport source (output valid, cmd, data_byte, end_of_buffer, slot_index, slot_valid,
                  slot_template, slot_offset, slot_kind, slot_length, input ready);
  modport sink (input valid, cmd, data_byte, end_of_buffer, slot_index, slot_valid,
                slot_template, slot_offset, slot_kind, slot_length, output ready);
endinterface
`default_nettype wire

>>> rtl/sbefx_out_if.sv
// Output channel: field values and error results.
`default_nettype none
interface sbefx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] template_id;
  logic [4:0]  field_slot;
  logic [3:0]  field_kind;
  logic [63:0] value;
  logic [3:0]  byte_count;
  logic        field_done;
  logic        last;

  modport source (output valid, status, template_id, field_slot, field_kind, value,
                  byte_count, field_done, last, input ready);
  modport sink (input valid, status, template_id, field_slot, field_kind, value,
                byte_count, field_done, last, output ready);
endinterface
`default_nettype wire

>>> rtl/sbefx_front.sv
// Front end: descriptor table, header parsing and body capture.
`default_nettype none
module sbefx_front #(
  parameter int HEADER_BYTES = sbefx_pkg::HEADER_BYTES_DEF,
  parameter int BODY_BYTES   = sbefx_pkg::BODY_BYTES_DEF,
  parameter int FIELD_SLOTS  = sbefx_pkg::FIELD_SLOTS_DEF
) (
  input  wire                                      clk,
  input  wire                                      rst,
  sbefx_in_if.sink                                 items,
  output sbefx_pkg::job_t                          job,
  output logic                                     job_push,
  input  wire                                      q_full,
  input  wire                                      back_done,
  input  wire                                      back_walk,
  input  wire [15:0]                               walk_tmpl,
  input  wire [(FIELD_SLOTS > 1 ? $clog2(FIELD_SLOTS) : 1)-1:0] rd_slot,
  output sbefx_pkg::slot_t                         rd_entry,
  output logic [FIELD_SLOTS-1:0]                   match,
  output logic                                     mem_we,
  output logic [$clog2(BODY_BYTES)-1:0]            mem_addr,
  output logic [7:0]                               mem_data
);
  localparam int SW = (FIELD_SLOTS > 1) ? $clog2(FIELD_SLOTS) : 1;
  localparam int AW = $clog2(BODY_BYTES);

  typedef enum logic [2:0] {F_HDR, F_BODY, F_DISC, F_CHECK, F_WAIT} fstate_t;

  fstate_t          state;
  sbefx_pkg::slot_t tbl [FIELD_SLOTS];
  logic [FIELD_SLOTS-1:0] tvalid;
  logic [7:0]       hdr [4];
  logic [15:0]      cnt;
  logic [15:0]      blen;
  logic [15:0]      cur_tmpl;
  logic             eob_l;

  logic [15:0] cnt_next;
  logic [15:0] hdr_tmpl;
  logic [15:0] hdr_blen;
  logic [15:0] cmp_tmpl;
  logic        known;
  logic        too_large;
  logic        hdr_last;
  logic        acc;
  logic        is_byte;

  assign cnt_next  = cnt + 16'd1;
  assign hdr_tmpl  = {hdr[3], hdr[2]};
  assign hdr_blen  = {hdr[1], hdr[0]};
  assign too_large = 32'(hdr_blen) > BODY_BYTES;
  assign hdr_last  = 32'(cnt_next) >= HEADER_BYTES;
  assign cmp_tmpl  = back_walk ? walk_tmpl : hdr_tmpl;

  assign items.ready = !q_full && (state == F_HDR || state == F_BODY || state == F_DISC);
  assign acc         = items.valid && items.ready;
  assign is_byte     = acc && (items.cmd == sbefx_pkg::CMD_BYTE);

  // Slot match vector against the template under test.
  always_comb begin
    for (int s = 0; s < FIELD_SLOTS; s++) begin
      match[s] = tvalid[s] && (tbl[s].tmpl == cmp_tmpl);
    end
  end
  assign known = |match;

  // Table read port for the back end.
  always_comb begin
    rd_entry       = tbl[rd_slot];
    rd_entry.valid = tvalid[rd_slot];
  end

  // Body capture goes straight into the back end's buffer.
  assign mem_we   = is_byte && (state == F_BODY);
  assign mem_addr = AW'(cnt);
  assign mem_data = items.data_byte;

  // Job issue.
  always_comb begin
    job_push    = 1'b0;
    job.emit    = 1'b0;
    job.status  = sbefx_pkg::ST_INCOMPLETE;
    job.tmpl    = cur_tmpl;
    job.blen    = blen;
    case (state)
      F_HDR: begin
        if (is_byte && !hdr_last && items.end_of_buffer) begin
          job_push = 1'b1;
          job.tmpl = 16'd0;
        end
      end
      F_CHECK: begin
        job.tmpl = hdr_tmpl;
        job.blen = hdr_blen;
        if (!q_full) begin
          job_push = 1'b1;
          if (!known) begin
            job.status = sbefx_pkg::ST_UNKNOWN;
          end else if (too_large) begin
            job.status = sbefx_pkg::ST_TOO_LARGE;
          end else if (hdr_blen == 16'd0) begin
            job.emit = 1'b1;
          end else if (!eob_l) begin
            job_push = 1'b0;
          end
        end
      end
      F_BODY: begin
        if (is_byte) begin
          if (cnt_next >= blen) begin
            job_push = 1'b1;
            job.emit = 1'b1;
          end else if (items.end_of_buffer) begin
            job_push = 1'b1;
          end
        end
      end
      default: begin
        job_push = 1'b0;
      end
    endcase
  end

  // Descriptor loads.
  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= '0;
    end else if (acc && items.cmd == sbefx_pkg::CMD_LOAD &&
                 32'(items.slot_index) < FIELD_SLOTS) begin
      tvalid[SW'(items.slot_index)]        <= items.slot_valid;
      tbl[SW'(items.slot_index)].tmpl      <= items.slot_template;
      tbl[SW'(items.slot_index)].offset    <= items.slot_offset;
      tbl[SW'(items.slot_index)].kind      <= items.slot_kind;
      tbl[SW'(items.slot_index)].length    <= items.slot_length;
      tbl[SW'(items.slot_index)].valid     <= items.slot_valid;
    end
  end

  // Message parser.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_HDR;
      cnt      <= '0;
      blen     <= '0;
      cur_tmpl <= '0;
      eob_l    <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        hdr[i] <= '0;
      end
    end else begin
      case (state)
        F_HDR: begin
          if (is_byte) begin
            if (cnt == 16'd0) begin
              cur_tmpl <= '0;
            end
            if (cnt < 16'd4) begin
              hdr[cnt[1:0]] <= items.data_byte;
            end
            if (hdr_last) begin
              cnt   <= '0;
              eob_l <= items.end_of_buffer;
              state <= F_CHECK;
            end else if (items.end_of_buffer) begin
              cnt <= '0;
            end else begin
              cnt <= cnt_next;
            end
          end
        end
        F_CHECK: begin
          if (!q_full) begin
            cur_tmpl <= hdr_tmpl;
            blen     <= hdr_blen;
            if (!known || too_large) begin
              state <= (hdr_blen != 16'd0 && !eob_l) ? F_DISC : F_HDR;
            end else if (hdr_blen == 16'd0) begin
              state <= F_WAIT;
            end else if (eob_l) begin
              state <= F_HDR;
            end else begin
              state <= F_BODY;
            end
          end
        end
        F_BODY: begin
          if (is_byte) begin
            if (cnt_next >= blen) begin
              cnt   <= '0;
              state <= F_WAIT;
            end else if (items.end_of_buffer) begin
              cnt   <= '0;
              state <= F_HDR;
            end else begin
              cnt <= cnt_next;
            end
          end
        end
        F_DISC: begin
          if (is_byte) begin
            if (cnt_next >= blen || items.end_of_buffer) begin
              cnt   <= '0;
              state <= F_HDR;
            end else begin
              cnt <= cnt_next;
            end
          end
        end
        F_WAIT: begin
          if (back_done) begin
            state <= F_HDR;
          end
        end
        default: begin
          state <= F_HDR;
        end
      endcase
    end
  end

  // While the walk runs, neither the table nor the body may change.
  a_wait_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == F_WAIT) |-> !items.ready)
    else $error("input taken while the field walk is pending");
  a_emit_waits: assert property (@(posedge clk) disable iff (rst)
    (job_push && job.emit) |=> (state == F_WAIT))
    else $error("field job issued without holding the front");

endmodule
`default_nettype wire

>>> rtl/sbefx_queue.sv
// Two-entry job queue between the front and back ends.
`default_nettype none
module sbefx_queue (
  input  wire             clk,
  input  wire             rst,
  input  sbefx_pkg::job_t din,
  input  wire             push,
  output logic            full,
  output sbefx_pkg::job_t dout,
  output logic            nonempty,
  input  wire             pop
);
  sbefx_pkg::job_t e0;
  sbefx_pkg::job_t e1;
  logic [1:0]      cnt;

  assign full     = (cnt == 2'd2);
  assign nonempty = (cnt != 2'd0);
  assign dout     = e0;

  // Shift-out queue: the head always sits in the first entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case ({push, pop})
        2'b10: begin
          if (cnt == 2'd0) begin
            e0 <= din;
          end else begin
            e1 <= din;
          end
          cnt <= cnt + 2'd1;
        end
        2'b01: begin
          e0  <= e1;
          cnt <= cnt - 2'd1;
        end
        2'b11: begin
          if (cnt == 2'd1) begin
            e0 <= din;
          end else begin
            e0 <= e1;
            e1 <= din;
          end
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("job popped from an empty queue");

endmodule
`default_nettype wire

>>> rtl/sbefx_back.sv
// Back end: body buffer, descriptor walk and result register.
`default_nettype none
module sbefx_back #(
  parameter int BODY_BYTES   = sbefx_pkg::BODY_BYTES_DEF,
  parameter int FIELD_SLOTS  = sbefx_pkg::FIELD_SLOTS_DEF,
  parameter int STRING_BYTES = sbefx_pkg::STRING_BYTES_DEF
) (
  input  wire                                      clk,
  input  wire                                      rst,
  input  sbefx_pkg::job_t                          job,
  input  wire                                      q_valid,
  output logic                                     q_pop,
  output logic                                     back_done,
  output logic                                     back_walk,
  output logic [15:0]                              walk_tmpl,
  output logic [(FIELD_SLOTS > 1 ? $clog2(FIELD_SLOTS) : 1)-1:0] rd_slot,
  input  sbefx_pkg::slot_t                         rd_entry,
  input  wire [FIELD_SLOTS-1:0]                    match,
  input  wire                                      mem_we,
  input  wire [$clog2(BODY_BYTES)-1:0]             mem_addr,
  input  wire [7:0]                                mem_data,
  sbefx_out_if.source                              results
);
  localparam int SW = (FIELD_SLOTS > 1) ? $clog2(FIELD_SLOTS) : 1;
  localparam int AW = $clog2(BODY_BYTES);
  localparam int LW = $clog2(STRING_BYTES + 1);
  localparam int PW = sbefx_pkg::POS_W;

  typedef enum logic [3:0] {
    B_IDLE, B_MASK, B_PICK, B_SETUP, B_TRIM_RD, B_TRIM_CK,
    B_CHUNK, B_RD, B_CAP, B_OUT, B_ERR
  } bstate_t;

  bstate_t                  state;
  logic [7:0]               mem [BODY_BYTES];
  logic [7:0]               rd_data;
  logic                     rd_ok;
  logic                     is_emit;
  logic [1:0]               err_status;
  logic [15:0]              tmpl;
  logic [15:0]              blen;
  logic [FIELD_SLOTS-1:0]   mask;
  logic [SW-1:0]            cur_s;
  logic [LW-1:0]            len;
  logic [LW-1:0]            pos;
  logic [3:0]               idx;
  logic [3:0]               ccnt;
  logic [63:0]              acc;
  logic [sbefx_pkg::RES_W-1:0] nres;

  logic [PW-1:0]  rd_pos;
  logic [7:0]     rdb;
  logic [SW-1:0]  low;
  logic           is_str;
  logic [LW-1:0]  len_clamp;
  logic [LW-1:0]  rem;
  logic [3:0]     chunk_cnt;
  logic [3:0]     nbytes;
  logic           fdone;
  logic           flast;
  logic           out_free;
  logic [63:0]    fvalue;
  logic [3:0]     fcount;
  logic           sgn;
  logic           res_load;

  assign rd_slot   = cur_s;
  assign walk_tmpl = tmpl;
  assign back_walk = (state == B_MASK);
  assign out_free  = !results.valid || results.ready;
  assign q_pop     = (state == B_IDLE) && q_valid;
  assign is_str    = (rd_entry.kind == sbefx_pkg::KIND_STRING);
  assign rdb       = rd_ok ? rd_data : 8'd0;
  assign res_load  = out_free && (state == B_OUT || state == B_ERR);

  // Lowest slot still to visit.
  always_comb begin
    low = '0;
    for (int s = FIELD_SLOTS - 1; s >= 0; s--) begin
      if (mask[s]) begin
        low = SW'(s);
      end
    end
  end

  // Field geometry of the current slot.
  always_comb begin
    if (32'(rd_entry.length) > STRING_BYTES) begin
      len_clamp = LW'(STRING_BYTES);
    end else begin
      len_clamp = LW'(rd_entry.length);
    end
    rem = len - pos;
    if (32'(rem) > 8) begin
      chunk_cnt = 4'd8;
    end else begin
      chunk_cnt = 4'(rem);
    end
    if (rd_entry.kind < sbefx_pkg::KIND_CHAR) begin
      nbytes = 4'd1 << rd_entry.kind[1:0];
    end else if (rd_entry.kind == sbefx_pkg::KIND_CHAR) begin
      nbytes = 4'd1;
    end else begin
      nbytes = 4'd0;
    end
  end

  // Body read address: trailing byte while trimming, else the next chunk byte.
  always_comb begin
    if (state == B_TRIM_RD) begin
      rd_pos = PW'(rd_entry.offset) + PW'(len) - PW'(1);
    end else begin
      rd_pos = PW'(rd_entry.offset) + PW'(pos) + PW'(idx);
    end
  end

  // Result value with sign extension for the signed integer codes.
  always_comb begin
    sgn    = (rd_entry.kind < sbefx_pkg::KIND_CHAR) && rd_entry.kind[2];
    fvalue = acc;
    if (rd_entry.kind < sbefx_pkg::KIND_CHAR) begin
      case (rd_entry.kind[1:0])
        2'd0:    fvalue = {{56{sgn & acc[7]}}, acc[7:0]};
        2'd1:    fvalue = {{48{sgn & acc[15]}}, acc[15:0]};
        2'd2:    fvalue = {{32{sgn & acc[31]}}, acc[31:0]};
        default: fvalue = acc;
      endcase
    end
    if (is_str) begin
      fcount = ccnt;
    end else if (rd_entry.kind == sbefx_pkg::KIND_CHAR) begin
      fcount = 4'd1;
    end else begin
      fcount = 4'd0;
    end
    fdone = !is_str || (32'(pos) + 32'(ccnt) >= 32'(len));
    flast = (fdone && mask == '0) || (32'(nres) == sbefx_pkg::MAX_RESULTS - 1);
  end

  // Body buffer with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_data;
    end
    rd_data <= mem[AW'(rd_pos)];
    rd_ok   <= 16'(rd_pos) < blen;
  end

  // Completion pulse once the final result of a field walk is registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      back_done <= 1'b0;
    end else begin
      back_done <= res_load && ((state == B_OUT && flast) || (state == B_ERR && is_emit));
    end
  end

  // Walk sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      results.valid <= 1'b0;
      is_emit       <= 1'b0;
      mask          <= '0;
      nres          <= '0;
      blen          <= '0;
    end else begin
      if (results.valid && results.ready && !res_load) begin
        results.valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            is_emit    <= job.emit;
            err_status <= job.status;
            tmpl       <= job.tmpl;
            blen       <= job.blen;
            nres       <= '0;
            state      <= job.emit ? B_MASK : B_ERR;
          end
        end
        B_MASK: begin
          mask  <= match;
          state <= B_PICK;
        end
        B_PICK: begin
          if (mask == '0) begin
            err_status <= sbefx_pkg::ST_UNKNOWN;
            state      <= B_ERR;
          end else begin
            cur_s <= low;
            mask  <= mask & ~(FIELD_SLOTS'(1) << low);
            state <= B_SETUP;
          end
        end
        B_SETUP: begin
          pos <= '0;
          len <= len_clamp;
          if (is_str && len_clamp != '0) begin
            state <= B_TRIM_RD;
          end else begin
            state <= B_CHUNK;
          end
        end
        B_TRIM_RD: begin
          state <= B_TRIM_CK;
        end
        B_TRIM_CK: begin
          if (rdb == sbefx_pkg::PAD_NUL || rdb == sbefx_pkg::PAD_SPACE) begin
            len   <= len - LW'(1);
            state <= (len == LW'(1)) ? B_CHUNK : B_TRIM_RD;
          end else begin
            state <= B_CHUNK;
          end
        end
        B_CHUNK: begin
          acc  <= '0;
          idx  <= '0;
          ccnt <= is_str ? chunk_cnt : nbytes;
          if ((is_str ? chunk_cnt : nbytes) == 4'd0) begin
            state <= B_OUT;
          end else begin
            state <= B_RD;
          end
        end
        B_RD: begin
          state <= B_CAP;
        end
        B_CAP: begin
          acc[idx[2:0]*8 +: 8] <= rdb;
          if (idx + 4'd1 == ccnt) begin
            state <= B_OUT;
          end else begin
            idx   <= idx + 4'd1;
            state <= B_RD;
          end
        end
        B_OUT: begin
          if (out_free) begin
            results.valid       <= 1'b1;
            results.status      <= sbefx_pkg::ST_FIELD;
            results.template_id <= tmpl;
            results.field_slot  <= 5'(cur_s);
            results.field_kind  <= rd_entry.kind;
            results.value       <= fvalue;
            results.byte_count  <= fcount;
            results.field_done  <= fdone;
            results.last        <= flast;
            nres                <= nres + 1'b1;
            if (flast) begin
              state <= B_IDLE;
            end else if (!fdone) begin
              pos   <= pos + LW'(ccnt);
              state <= B_CHUNK;
            end else begin
              state <= B_PICK;
            end
          end
        end
        B_ERR: begin
          if (out_free) begin
            results.valid       <= 1'b1;
            results.status      <= err_status;
            results.template_id <= tmpl;
            results.field_slot  <= '0;
            results.field_kind  <= '0;
            results.value       <= '0;
            results.byte_count  <= '0;
            results.field_done  <= 1'b0;
            results.last        <= 1'b1;
            state               <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.status != sbefx_pkg::ST_FIELD) |-> results.last)
    else $error("error result not marked as final");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    back_done |-> (state == B_IDLE))
    else $error("walk reported done while still busy");

endmodule
`default_nettype wire

>>> rtl/sbe_message_field_extractor.sv
// Top level of the message field extractor: front end, job queue and back end.
//
// Usage: the items channel carries descriptor loads (cmd 0) and message
// bytes (cmd 1); the results channel carries one transfer per field chunk
// or per error. A transfer happens when valid and ready are both high.
// Header and body bytes are taken at one per cycle unless the job queue is full
// or a field walk is pending; after the last header byte the front looks the
// template up in the table in a check state. Error results pass through the job
// queue and the back end's error state into the output register. When a message
// completes, input is held off while the back end walks the table: for each
// matching slot it sets up the slot, trims trailing padding from a string one
// byte at a time, reads each chunk's body bytes one by one and issues a result.
// A result waits in the output register while the receiver stalls; the walk
// and, once the two-entry job queue fills, the input stall behind it.
// Reset clears every slot to invalid, drops any message in progress and
// empties the queue and the output register; the body buffer is not cleared.
`default_nettype none
module sbe_message_field_extractor #(
  parameter int HEADER_BYTES = sbefx_pkg::HEADER_BYTES_DEF,
  parameter int BODY_BYTES   = sbefx_pkg::BODY_BYTES_DEF,
  parameter int FIELD_SLOTS  = sbefx_pkg::FIELD_SLOTS_DEF,
  parameter int STRING_BYTES = sbefx_pkg::STRING_BYTES_DEF
) (
  input wire          clk,
  input wire          rst,
  sbefx_in_if.sink    items,
  sbefx_out_if.source results
);
  localparam int SW = (FIELD_SLOTS > 1) ? $clog2(FIELD_SLOTS) : 1;
  localparam int AW = $clog2(BODY_BYTES);

  sbefx_pkg::job_t  job_in;
  sbefx_pkg::job_t  job_out;
  logic             job_push;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic             back_done;
  logic             back_walk;
  logic [15:0]      walk_tmpl;
  logic [SW-1:0]    rd_slot;
  sbefx_pkg::slot_t rd_entry;
  logic [FIELD_SLOTS-1:0] match;
  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  logic [7:0]       mem_data;

  // Parser and descriptor table.
  sbefx_front #(
    .HEADER_BYTES(HEADER_BYTES),
    .BODY_BYTES  (BODY_BYTES),
    .FIELD_SLOTS (FIELD_SLOTS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .items    (items),
    .job      (job_in),
    .job_push (job_push),
    .q_full   (q_full),
    .back_done(back_done),
    .back_walk(back_walk),
    .walk_tmpl(walk_tmpl),
    .rd_slot  (rd_slot),
    .rd_entry (rd_entry),
    .match    (match),
    .mem_we   (mem_we),
    .mem_addr (mem_addr),
    .mem_data (mem_data)
  );

  // Job queue.
  sbefx_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .din     (job_in),
    .push    (job_push),
    .full    (q_full),
    .dout    (job_out),
    .nonempty(q_valid),
    .pop     (q_pop)
  );

  // Field walk and results.
  sbefx_back #(
    .BODY_BYTES  (BODY_BYTES),
    .FIELD_SLOTS (FIELD_SLOTS),
    .STRING_BYTES(STRING_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job      (job_out),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .back_done(back_done),
    .back_walk(back_walk),
    .walk_tmpl(walk_tmpl),
    .rd_slot  (rd_slot),
    .rd_entry (rd_entry),
    .match    (match),
    .mem_we   (mem_we),
    .mem_addr (mem_addr),
    .mem_data (mem_data),
    .results  (results)
  );

  a_done_drained: assert property (@(posedge clk) disable iff (rst)
    back_done |-> !q_valid)
    else $error("job queued behind a field walk");

endmodule
`default_nettype wire
